/* design/forward_kinematics_six_joint_assert.svh */
// ----------------------------------------------------------------------------
// forward_kinematics_six_joint_assert.svh
// Assertion macros for the forward kinematics block.
// ----------------------------------------------------------------------------
`ifndef FORWARD_KINEMATICS_SIX_JOINT_ASSERT_SVH
`define FORWARD_KINEMATICS_SIX_JOINT_ASSERT_SVH

// same-cycle implication
`define FKSJ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FKSJ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/fksj_pkg.sv */
// ----------------------------------------------------------------------------
// fksj_pkg
// Shared constants, types and tables for the forward kinematics block.
// ----------------------------------------------------------------------------
package fksj_pkg;

    localparam int JOINTS       = 6;
    localparam int NREG         = 6;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_W        = 60;
    localparam int ANG_W        = 20;
    localparam int LEN_W        = 20;
    localparam int CORDIC_ITERS = 24;

    localparam int Z_W   = 36;   // scaled angle before reduction, Q30
    localparam int CW    = 33;   // CORDIC datapath
    localparam int SC_W  = 30;   // sin/cos, Q28
    localparam int ROT_W = 31;   // rotation entries, Q28
    localparam int LP_W  = 29;   // link translation, Q8
    localparam int POS_W = 34;   // accumulated position, Q8

    localparam int ROT_OUT_W = 18;
    localparam int POS_OUT_W = 24;
    localparam int S_DATA_W  = 120;
    localparam int M_DATA_W  = 240;

    localparam logic signed [Z_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [Z_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [CW-1:0]  CORDIC_GAIN = 33'sd652032874;

    typedef struct {
        logic signed [ROT_W-1:0] r [3][3];
        logic signed [LP_W-1:0]  p [3];
    } link_t;

    typedef struct {
        logic signed [ROT_W-1:0] r [3][3];
        logic signed [POS_W-1:0] p [3];
    } pose_t;

    function automatic logic signed [CW-1:0] atan_q30(input int i);
        logic signed [CW-1:0] t;
        t = '0;
        case (i)
            0:       t = 33'sd843314857;
            1:       t = 33'sd497837829;
            2:       t = 33'sd263043837;
            3:       t = 33'sd133525159;
            4:       t = 33'sd67021688;
            5:       t = 33'sd33543516;
            6:       t = 33'sd16775851;
            7:       t = 33'sd8388437;
            8:       t = 33'sd4194283;
            9:       t = 33'sd2097149;
            default: t[30-i] = 1'b1;
        endcase
        return t;
    endfunction

endpackage

/* design/fksj_cordic.sv */
// ----------------------------------------------------------------------------
// fksj_cordic
// Pipelined sine/cosine: range reduction, 24 rotation stages, rounding.
// ----------------------------------------------------------------------------
module fksj_cordic (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [fksj_pkg::ANG_W-1:0] angle,
    output logic signed [fksj_pkg::SC_W-1:0]  sin_out,
    output logic signed [fksj_pkg::SC_W-1:0]  cos_out
);

    localparam int N = fksj_pkg::CORDIC_ITERS;

    logic signed [fksj_pkg::CW-1:0] x_reg [0:N];
    logic signed [fksj_pkg::CW-1:0] y_reg [0:N];
    logic signed [fksj_pkg::CW-1:0] z_reg [0:N];
    logic                           neg_reg [0:N];
    logic signed [fksj_pkg::SC_W-1:0] sin_reg, cos_reg;

    logic signed [fksj_pkg::Z_W-1:0] z_full, z_wrap, z_fold;
    logic                            neg_next;
    logic signed [fksj_pkg::CW-1:0]  x_rnd, y_rnd;

    always_comb begin
        z_full = {{(fksj_pkg::Z_W-fksj_pkg::ANG_W-14){angle[fksj_pkg::ANG_W-1]}},
                  angle, 14'b0};
        if (z_full > fksj_pkg::PI_Q30) begin
            z_wrap = z_full - fksj_pkg::TWO_PI_Q30;
        end else if (z_full < -fksj_pkg::PI_Q30) begin
            z_wrap = z_full + fksj_pkg::TWO_PI_Q30;
        end else begin
            z_wrap = z_full;
        end
        neg_next = 1'b0;
        z_fold   = z_wrap;
        if (z_wrap > fksj_pkg::HALF_PI_Q30) begin
            z_fold   = z_wrap - fksj_pkg::PI_Q30;
            neg_next = 1'b1;
        end else if (z_wrap < -fksj_pkg::HALF_PI_Q30) begin
            z_fold   = z_wrap + fksj_pkg::PI_Q30;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= fksj_pkg::CORDIC_GAIN;
            y_reg[0]   <= '0;
            z_reg[0]   <= z_fold[fksj_pkg::CW-1:0];
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        localparam logic signed [fksj_pkg::CW-1:0] ATAN = fksj_pkg::atan_q30(i);
        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[i+1] <= neg_reg[i];
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
            end
        end
    end

    assign x_rnd = (x_reg[N] + 33'sd2) >>> 2;
    assign y_rnd = (y_reg[N] + 33'sd2) >>> 2;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (neg_reg[N]) begin
                cos_reg <= -x_rnd[fksj_pkg::SC_W-1:0];
                sin_reg <= -y_rnd[fksj_pkg::SC_W-1:0];
            end else begin
                cos_reg <= x_rnd[fksj_pkg::SC_W-1:0];
                sin_reg <= y_rnd[fksj_pkg::SC_W-1:0];
            end
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

/* design/fksj_lane.sv */
// ----------------------------------------------------------------------------
// fksj_lane
// One joint: sin/cos of angle and twist, then the link transform.
// ----------------------------------------------------------------------------
module fksj_lane (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [fksj_pkg::ANG_W-1:0] angle,
    input  logic [fksj_pkg::CFG_W-1:0]        link_cfg,
    output fksj_pkg::link_t                   link
);

    localparam int PW = 2 * fksj_pkg::SC_W;
    localparam int DW = fksj_pkg::SC_W + fksj_pkg::LEN_W;

    logic signed [fksj_pkg::ANG_W-1:0] alpha;
    logic signed [fksj_pkg::LEN_W-1:0] len_a, len_d;
    logic signed [fksj_pkg::SC_W-1:0]  st, ct, sa, ca;

    logic signed [PW-1:0] st_ca_reg, ct_ca_reg, st_sa_reg, ct_sa_reg;
    logic signed [DW-1:0] sa_d_reg, ca_d_reg;
    logic signed [fksj_pkg::SC_W-1:0] st_reg, ct_reg, sa_reg, ca_reg;

    logic signed [PW-1:0] st_ca_r, ct_ca_r, st_sa_r, ct_sa_r;
    logic signed [DW-1:0] sa_d_r, ca_d_r;
    fksj_pkg::link_t link_out_reg;

    assign alpha = link_cfg[19:0];
    assign len_a = link_cfg[39:20];
    assign len_d = link_cfg[59:40];

    fksj_cordic u_theta (.aclk(aclk), .en(en), .angle(angle), .sin_out(st), .cos_out(ct));
    fksj_cordic u_alpha (.aclk(aclk), .en(en), .angle(alpha), .sin_out(sa), .cos_out(ca));

    always_ff @(posedge aclk) begin
        if (en) begin
            st_ca_reg <= st * ca;
            ct_ca_reg <= ct * ca;
            st_sa_reg <= st * sa;
            ct_sa_reg <= ct * sa;
            sa_d_reg  <= sa * len_d;
            ca_d_reg  <= ca * len_d;
            st_reg    <= st;
            ct_reg    <= ct;
            sa_reg    <= sa;
            ca_reg    <= ca;
        end
    end

    assign st_ca_r = (st_ca_reg + (60'sd1 <<< 27)) >>> 28;
    assign ct_ca_r = (ct_ca_reg + (60'sd1 <<< 27)) >>> 28;
    assign st_sa_r = (st_sa_reg + (60'sd1 <<< 27)) >>> 28;
    assign ct_sa_r = (ct_sa_reg + (60'sd1 <<< 27)) >>> 28;
    assign sa_d_r  = (-sa_d_reg + (50'sd1 <<< 19)) >>> 20;
    assign ca_d_r  = (ca_d_reg + (50'sd1 <<< 19)) >>> 20;

    always_ff @(posedge aclk) begin
        if (en) begin
            link_out_reg.r[0][0] <= fksj_pkg::ROT_W'(ct_reg);
            link_out_reg.r[0][1] <= -fksj_pkg::ROT_W'(st_reg);
            link_out_reg.r[0][2] <= '0;
            link_out_reg.r[1][0] <= st_ca_r[fksj_pkg::ROT_W-1:0];
            link_out_reg.r[1][1] <= ct_ca_r[fksj_pkg::ROT_W-1:0];
            link_out_reg.r[1][2] <= -fksj_pkg::ROT_W'(sa_reg);
            link_out_reg.r[2][0] <= st_sa_r[fksj_pkg::ROT_W-1:0];
            link_out_reg.r[2][1] <= ct_sa_r[fksj_pkg::ROT_W-1:0];
            link_out_reg.r[2][2] <= fksj_pkg::ROT_W'(ca_reg);
            link_out_reg.p[0]    <= {len_a[fksj_pkg::LEN_W-1], len_a, 8'b0};
            link_out_reg.p[1]    <= sa_d_r[fksj_pkg::LP_W-1:0];
            link_out_reg.p[2]    <= ca_d_r[fksj_pkg::LP_W-1:0];
        end
    end

    assign link = link_out_reg;

endmodule

/* design/fksj_chain_step.sv */
// ----------------------------------------------------------------------------
// fksj_chain_step
// Composes the running pose with one link transform, two stages.
// ----------------------------------------------------------------------------
module fksj_chain_step (
    input  logic            aclk,
    input  logic            en,
    input  fksj_pkg::pose_t pose_in,
    input  fksj_pkg::link_t link,
    output fksj_pkg::pose_t pose_out
);

    localparam int MW  = 2 * fksj_pkg::ROT_W;
    localparam int PMW = fksj_pkg::ROT_W + fksj_pkg::LP_W;
    localparam int SW  = MW + 2;
    localparam int PSW = PMW + 2;

    logic signed [MW-1:0]             prod_reg [3][3][3];
    logic signed [PMW-1:0]            posp_reg [3][3];
    logic signed [fksj_pkg::POS_W-1:0] p_reg [3];
    logic signed [SW-1:0]             rsum [3][3];
    logic signed [PSW-1:0]            psum [3];
    fksj_pkg::pose_t                  pose_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int row = 0; row < 3; row++) begin
                p_reg[row] <= pose_in.p[row];
                for (int k = 0; k < 3; k++) begin
                    posp_reg[row][k] <= pose_in.r[row][k] * link.p[k];
                    for (int col = 0; col < 3; col++) begin
                        prod_reg[row][col][k] <= pose_in.r[row][k] * link.r[k][col];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int row = 0; row < 3; row++) begin
            psum[row] = (PSW'(posp_reg[row][0]) + PSW'(posp_reg[row][1])
                        + PSW'(posp_reg[row][2]) + (PSW'(1) <<< 27)) >>> 28;
            for (int col = 0; col < 3; col++) begin
                rsum[row][col] = (SW'(prod_reg[row][col][0]) + SW'(prod_reg[row][col][1])
                                 + SW'(prod_reg[row][col][2]) + (SW'(1) <<< 27)) >>> 28;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int row = 0; row < 3; row++) begin
                pose_reg.p[row] <= psum[row][fksj_pkg::POS_W-1:0] + p_reg[row];
                for (int col = 0; col < 3; col++) begin
                    pose_reg.r[row][col] <= rsum[row][col][fksj_pkg::ROT_W-1:0];
                end
            end
        end
    end

    assign pose_out = pose_reg;

endmodule

/* design/forward_kinematics_six_joint.sv */
// An accepted s_ beat passes through the joint lanes, the composition chain
// and the output register before it reaches m_tvalid.
// Throughput: one pose per cycle unless a held result stalls the pipeline; each
// lane runs fully pipelined 24-stage CORDIC units, so nothing is shared between beats.
// Reset: link registers clear to zero, the pipeline and output empty.
// ----------------------------------------------------------------------------
// forward_kinematics_six_joint
// Six-joint modified-DH forward kinematics, parallel joint lanes + chain.
// ----------------------------------------------------------------------------
`include "forward_kinematics_six_joint_assert.svh"

module forward_kinematics_six_joint (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // joint1_angle .. joint6_angle, 20 bits each
    input  logic [fksj_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // rot_xx, rot_xy, rot_xz, rot_yx, rot_yy, rot_yz, rot_zx, rot_zy, rot_zz
    // (18 bits each), pos_x, pos_y, pos_z (24 bits each), 6 zero bits
    output logic [fksj_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fksj_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fksj_pkg::CFG_W-1:0]        cfg_data
);

    localparam int J     = fksj_pkg::JOINTS;
    localparam int DEPTH = 28 + 2 * J;
    localparam int LAST  = DEPTH - 1;
    localparam int RW    = fksj_pkg::ROT_OUT_W;
    localparam int PW    = fksj_pkg::POS_OUT_W;

    logic [fksj_pkg::CFG_W-1:0] link_cfg_reg [fksj_pkg::NREG];
    logic                       v_reg [0:LAST];
    logic                       m_tvalid_reg;
    logic [fksj_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                       adv;

    fksj_pkg::link_t lane_link [J];
    fksj_pkg::link_t step_link [J];
    fksj_pkg::pose_t pose [J+1];

    assign cfg_ready = 1'b1;
    assign adv       = m_tready || !m_tvalid_reg || !v_reg[LAST];
    assign s_tready  = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < fksj_pkg::NREG; i++) begin
                link_cfg_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready
                     && cfg_index < fksj_pkg::CFG_IDX_W'(fksj_pkg::NREG)) begin
            link_cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            v_reg[0] <= s_tvalid;
            for (int i = 1; i < DEPTH; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_comb begin
        for (int row = 0; row < 3; row++) begin
            pose[0].p[row] = '0;
            for (int col = 0; col < 3; col++) begin
                pose[0].r[row][col] = (row == col) ? (fksj_pkg::ROT_W'(1) <<< 28) : '0;
            end
        end
    end

    for (genvar j = 0; j < J; j++) begin : g_joint
        fksj_lane u_lane (
            .aclk     (aclk),
            .en       (adv),
            .angle    (s_tdata[j*fksj_pkg::ANG_W +: fksj_pkg::ANG_W]),
            .link_cfg (link_cfg_reg[j]),
            .link     (lane_link[j])
        );

        if (j == 0) begin : g_direct
            assign step_link[j] = lane_link[j];
        end else begin : g_delay
            fksj_pkg::link_t dly_reg [2*j];
            always_ff @(posedge aclk) begin
                if (adv) begin
                    dly_reg[0] <= lane_link[j];
                    for (int k = 1; k < 2 * j; k++) begin
                        dly_reg[k] <= dly_reg[k-1];
                    end
                end
            end
            assign step_link[j] = dly_reg[2*j-1];
        end

        fksj_chain_step u_step (
            .aclk     (aclk),
            .en       (adv),
            .pose_in  (pose[j]),
            .link     (step_link[j]),
            .pose_out (pose[j+1])
        );
    end

    always_comb begin
        logic signed [fksj_pkg::ROT_W-1:0] rr;
        logic signed [fksj_pkg::POS_W-1:0] pr;
        m_tdata_next = '0;
        for (int row = 0; row < 3; row++) begin
            for (int col = 0; col < 3; col++) begin
                rr = (pose[J].r[row][col] + fksj_pkg::ROT_W'(2048)) >>> 12;
                if (rr > fksj_pkg::ROT_W'(65536)) begin
                    rr = fksj_pkg::ROT_W'(65536);
                end else if (rr < -fksj_pkg::ROT_W'(65536)) begin
                    rr = -fksj_pkg::ROT_W'(65536);
                end
                m_tdata_next[(row*3+col)*RW +: RW] = rr[RW-1:0];
            end
            pr = (pose[J].p[row] + fksj_pkg::POS_W'(128)) >>> 8;
            if (pr > fksj_pkg::POS_W'(8388607)) begin
                pr = fksj_pkg::POS_W'(8388607);
            end else if (pr < -fksj_pkg::POS_W'(8388608)) begin
                pr = -fksj_pkg::POS_W'(8388608);
            end
            m_tdata_next[9*RW + row*PW +: PW] = pr[PW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (!m_tvalid_reg || m_tready) begin
            m_tvalid_reg <= v_reg[LAST];
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_tvalid_reg || m_tready) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `FKSJ_ASSERT_NXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready, v_reg[0], "accepted beat lost at pipeline entry")
    `FKSJ_ASSERT_IMP(a_full_tail_stalls, aclk, aresetn, v_reg[LAST] && m_tvalid && !m_tready, !s_tready, "pipeline advanced over a held result")
    `FKSJ_ASSERT_IMP(a_out_from_tail, aclk, aresetn, $rose(m_tvalid), $past(v_reg[LAST]), "result without a pipeline tail beat")

endmodule
